// ===== design/jtl_pkg.sv =====
package jtl_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [3:0] token_kind;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       token_done;
		logic       bool_value;
		logic [1:0] error_code;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_STRING  = 3'd1,
		MODE_ESCAPE  = 3'd2,
		MODE_NUMBER  = 3'd3,
		MODE_LITERAL = 3'd4
	} lex_mode_t;

	localparam logic [3:0] KIND_END      = 4'd0;
	localparam logic [3:0] KIND_LBRACE   = 4'd1;
	localparam logic [3:0] KIND_RBRACE   = 4'd2;
	localparam logic [3:0] KIND_LBRACKET = 4'd3;
	localparam logic [3:0] KIND_RBRACKET = 4'd4;
	localparam logic [3:0] KIND_STRING   = 4'd5;
	localparam logic [3:0] KIND_NUMBER   = 4'd6;
	localparam logic [3:0] KIND_BOOLEAN  = 4'd7;
	localparam logic [3:0] KIND_COLON    = 4'd8;
	localparam logic [3:0] KIND_COMMA    = 4'd9;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
	localparam logic [1:0] ERR_LITERAL  = 2'd2;
	localparam logic [1:0] ERR_UNTERM   = 2'd3;

	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;

	localparam logic [7:0] WORD_TRUE  [0:3] = '{8'h74, 8'h72, 8'h75, 8'h65};
	localparam logic [7:0] WORD_FALSE [0:4] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	// results produced by one item, in order
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} lex_push_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             room;
	} fifo_stat_t;

	function automatic out_item_t mk_res(logic [3:0] kind, logic [7:0] data, logic dv,
			logic done, logic bv, logic [1:0] err);
		out_item_t r;
		r.token_kind = kind;
		r.data_byte  = data;
		r.data_valid = dv;
		r.token_done = done;
		r.bool_value = bv;
		r.error_code = err;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

// ===== design/jtl_lexer.sv =====
module jtl_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  jtl_pkg::in_item_t item,
	output jtl_pkg::lex_push_t push
);
	import jtl_pkg::*;

	lex_mode_t  mode_q, mode_d;
	logic [2:0] lit_pos_q, lit_pos_d;
	logic       lit_true_q, lit_true_d;
	logic       err_q, err_d;

	logic [7:0] c;
	logic       eot;
	logic       is_digit;

	// token start from between tokens
	logic       idle_v;
	out_item_t  idle_res;
	lex_mode_t  idle_mode;
	logic       idle_lit;
	logic       idle_lit_true;
	logic       idle_err;

	logic       pre_v, main_v;
	out_item_t  pre_res, main_res;
	logic [2:0] lit_len, lit_pos_inc;
	logic [7:0] want;
	logic       lit_match;

	assign c        = item.char_in;
	assign eot      = item.end_of_text || (c == 8'h00);
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

	always_comb begin
		idle_v        = 1'b1;
		idle_res      = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
		idle_mode     = MODE_IDLE;
		idle_lit      = 1'b0;
		idle_lit_true = 1'b0;
		idle_err      = 1'b0;
		case (c)
			CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
				idle_v = 1'b0;
			end
			CH_LBRACE:   idle_res.token_kind = KIND_LBRACE;
			CH_RBRACE:   idle_res.token_kind = KIND_RBRACE;
			CH_LBRACKET: idle_res.token_kind = KIND_LBRACKET;
			CH_RBRACKET: idle_res.token_kind = KIND_RBRACKET;
			CH_COLON:    idle_res.token_kind = KIND_COLON;
			CH_COMMA:    idle_res.token_kind = KIND_COMMA;
			CH_QUOTE: begin
				idle_v    = 1'b0;
				idle_mode = MODE_STRING;
			end
			CH_T, CH_F: begin
				idle_v        = 1'b0;
				idle_mode     = MODE_LITERAL;
				idle_lit      = 1'b1;
				idle_lit_true = (c == CH_T);
			end
			default: begin
				if (c == CH_MINUS || is_digit) begin
					idle_mode = MODE_NUMBER;
					idle_res  = mk_res(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
				end else begin
					idle_res.error_code = ERR_UNKNOWN;
					idle_err            = 1'b1;
				end
			end
		endcase
	end

	assign lit_len     = lit_true_q ? 3'd4 : 3'd5;
	assign lit_pos_inc = lit_pos_q + 3'd1;
	assign want        = lit_true_q ? WORD_TRUE[lit_pos_q[1:0]]
		: WORD_FALSE[(lit_pos_q < 3'd5) ? lit_pos_q : 3'd4];
	assign lit_match   = (lit_pos_q < lit_len) && (c == want);

	always_comb begin
		mode_d     = mode_q;
		lit_pos_d  = lit_pos_q;
		lit_true_d = lit_true_q;
		err_d      = err_q;
		pre_v      = 1'b0;
		pre_res    = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
		main_v     = 1'b0;
		main_res   = idle_res;
		if (eot) begin
			if (!err_q) begin
				case (mode_q)
					MODE_NUMBER: pre_v = 1'b1;
					MODE_STRING, MODE_ESCAPE: begin
						pre_v   = 1'b1;
						pre_res = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, ERR_UNTERM);
					end
					MODE_LITERAL: begin
						pre_v   = 1'b1;
						pre_res = mk_res(KIND_BOOLEAN, 8'h00, 1'b0, 1'b1, 1'b0, ERR_UNTERM);
					end
					default: pre_v = 1'b0;
				endcase
			end
			main_v     = 1'b1;
			main_res   = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
			mode_d     = MODE_IDLE;
			lit_pos_d  = 3'd0;
			lit_true_d = 1'b0;
			err_d      = 1'b0;
		end else if (!err_q) begin
			case (mode_q)
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						mode_d   = MODE_IDLE;
						main_v   = 1'b1;
						main_res = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
					end else if (c == CH_BACKSLASH) begin
						mode_d = MODE_ESCAPE;
					end else begin
						main_v   = 1'b1;
						main_res = mk_res(KIND_STRING, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
					end
				end
				MODE_ESCAPE: begin
					mode_d   = MODE_STRING;
					main_v   = 1'b1;
					main_res = mk_res(KIND_STRING, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
				end
				MODE_NUMBER: begin
					if (is_digit) begin
						main_v   = 1'b1;
						main_res = mk_res(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
					end else begin
						// close the number, then lex this byte as a new token
						pre_v  = 1'b1;
						main_v = idle_v;
						mode_d = idle_mode;
						err_d  = idle_err;
						if (idle_lit) begin
							lit_pos_d  = 3'd1;
							lit_true_d = idle_lit_true;
						end
					end
				end
				MODE_LITERAL: begin
					main_v = 1'b0;
					if (lit_match) begin
						lit_pos_d = lit_pos_inc;
						if (lit_pos_inc == lit_len) begin
							main_v     = 1'b1;
							main_res   = mk_res(KIND_BOOLEAN, 8'h00, 1'b0, 1'b1,
								lit_true_q, ERR_NONE);
							mode_d     = MODE_IDLE;
							lit_pos_d  = 3'd0;
							lit_true_d = 1'b0;
						end
					end else begin
						main_v     = 1'b1;
						main_res   = mk_res(KIND_BOOLEAN, 8'h00, 1'b0, 1'b1, 1'b0, ERR_LITERAL);
						err_d      = 1'b1;
						mode_d     = MODE_IDLE;
						lit_pos_d  = 3'd0;
						lit_true_d = 1'b0;
					end
				end
				default: begin
					main_v = idle_v;
					mode_d = idle_mode;
					err_d  = idle_err;
					if (idle_lit) begin
						lit_pos_d  = 3'd1;
						lit_true_d = idle_lit_true;
					end
				end
			endcase
		end
	end

	// pack results in order and flag the final one
	always_comb begin
		push.count  = {1'b0, pre_v} + {1'b0, main_v};
		push.first  = pre_v ? pre_res : main_res;
		push.second = main_res;
		if (!fire) begin
			push.count = 2'd0;
		end
		if (pre_v && main_v) begin
			push.second.last = 1'b1;
		end else begin
			push.first.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			lit_pos_q  <= 3'd0;
			lit_true_q <= 1'b0;
			err_q      <= 1'b0;
		end else if (fire) begin
			mode_q     <= mode_d;
			lit_pos_q  <= lit_pos_d;
			lit_true_q <= lit_true_d;
			err_q      <= err_d;
		end
	end

endmodule

// ===== design/jtl_res_fifo.sv =====
module jtl_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  jtl_pkg::lex_push_t  push,
	output logic                out_valid,
	input  logic                out_ready,
	output jtl_pkg::out_item_t  out_data,
	output jtl_pkg::fifo_stat_t stat
);
	import jtl_pkg::*;

	out_item_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	logic [PTR_W-1:0] wr_next;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign wr_next   = wr_q + PTR_W'(1);

	// room for a full pair of results, decided from registered count only
	assign stat.count = cnt_q;
	assign stat.room  = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.count);
			cnt_q <= cnt_q + CNT_W'(push.count) - CNT_W'(pop);
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
		end
	end

endmodule

// ===== design/json_token_lexer_core.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// input    | in_valid / in_ready | in_data  (char_in, end_of_text)
// output   | out_valid/out_ready | out_data (token_kind .. last)
//
// One byte per cycle while the queue has room: a transfer lands in the input
// register, the lexer classifies it there and writes 0, 1 or 2 results into a
// 4-entry result queue. Items giving two results take two output transfers.
// A result passes the input register and then the result queue before output.
// The input register advances only while the queue has room for two results.
// Reset returns the lexer to between tokens with no error and empties the queue.
module json_token_lexer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jtl_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output jtl_pkg::out_item_t out_data
);
	import jtl_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       adv;
	lex_push_t  push;
	fifo_stat_t stat;

	assign adv      = valid_s1 && stat.room;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	jtl_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.push   (push)
	);

	jtl_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.stat      (stat)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_eot_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (item_s1.end_of_text || item_s1.char_in == 8'h00)) |-> (push.count != 2'd0))
		else $error("end of text produced no result");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> (push.count == 2'd0))
		else $error("results pushed without an item");

endmodule
